// ===== rtl/granular_shuffle_voices_core_defines.svh =====
// Assertion helpers shared by the checkers of this block.
`ifndef GRANULAR_SHUFFLE_VOICES_CORE_DEFINES_SVH
`define GRANULAR_SHUFFLE_VOICES_CORE_DEFINES_SVH

// Plain clocked property, active through reset.
`define GSV_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked property, ignored while reset is low.
`define GSV_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/gsv_pkg.sv =====
package gsv_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int START_W    = 12;
    localparam int GRAIN_W    = 13;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = 20;
    localparam int WIN_W      = 16;
    localparam int HOP_W      = 11;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP = 1'd1;

    localparam logic [GRAIN_W-1:0] GRAIN_MIN   = 13'd2;
    localparam logic [GRAIN_W-1:0] GRAIN_MAX   = 13'd4096;
    localparam logic [GRAIN_W-1:0] GRAIN_RESET = 13'd1024;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 21'd1025;

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Hann entry from a Q30 angle: Taylor sine to t^13, squared, to unsigned Q1.15.
    // Elaboration-time only.
    function automatic logic [WIN_W-1:0] hann_from_t(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] sq;
        logic [63:0] e;
        t2   = (t * t) >> 30;
        term = t;
        s    = t;
        for (int n = 1; n <= 6; n++) begin
            term = (term * t2) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n[0]) begin
                s = (s >= term) ? s - term : 64'd0;
            end else begin
                s = s + term;
            end
        end
        sq = (s * s) >> 30;
        e  = (sq + 64'd16384) >> 15;
        if (e > 64'd32768) begin
            e = 64'd32768;
        end
        return e[WIN_W-1:0];
    endfunction

endpackage

// ===== rtl/granular_shuffle_voices_core.sv =====
// Each sample goes through load, then select, multiply and accumulate for each voice in turn
// on one shared multiply-accumulate, then wrap and round; no input is taken until idle again.
// Load repeats, taking BUF_DEPTH off random_start while it is at least BUF_DEPTH; wrap
// repeats, taking grain_size off the start counter while it is at least grain_size (more
// often after grain_size is lowered); round waits for any result still held on the output.
// Reset is synchronous; store reads zero until written.
module granular_shuffle_voices_core #(
    parameter int BUF_DEPTH       = 4096,
    parameter int VOICES          = 4,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [gsv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gsv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [gsv_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // sample_in[15:0], random_start[27:16]
    input  logic                            s_axis_tlast,  // block_last
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [gsv_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // sample_out[15:0]
    output logic                            m_axis_tlast   // block_last_out
);
    import gsv_pkg::*;

    localparam int AW     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW     = $clog2(COS_TABLE_DEPTH);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VH_W   = GRAIN_W + $clog2(VOICES + 1);
    localparam int IDXP_W = PHASE_W + $clog2(COS_TABLE_DEPTH + 1);
    localparam int PROD_W = 2 * SAMPLE_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(VOICES + 1) + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_VSEL  = 3'd2;
    localparam logic [2:0] S_VMUL  = 3'd3;
    localparam logic [2:0] S_VACC  = 3'd4;
    localparam logic [2:0] S_WRAP  = 3'd5;
    localparam logic [2:0] S_ROUND = 3'd6;

    // window ROM, built at elaboration
    logic [WIN_W-1:0] w_win_rom [COS_TABLE_DEPTH];

    for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_win
        localparam int          X = (k <= COS_TABLE_DEPTH - k) ? k : COS_TABLE_DEPTH - k;
        localparam logic [63:0] T = (PI_Q30 * 64'(X)) / COS_TABLE_DEPTH;
        assign w_win_rom[k] = hann_from_t(T);
    end

    t_sample r_mem [BUF_DEPTH];

    logic [2:0]              r_state, n_state;
    logic [GRAIN_W-1:0]      r_grain_size;
    logic [STEP_W-1:0]       r_window_step;
    logic [AW-1:0]           r_waddr;
    logic                    r_wrapped;
    logic [GRAIN_W-1:0]      r_sc;

    logic                    r_active [VOICES];
    logic [AW-1:0]           r_raddr  [VOICES];
    logic [GRAIN_W-1:0]      r_pos    [VOICES];
    logic [PHASE_W-1:0]      r_phase  [VOICES];

    t_sample                 r_smp;
    logic [START_W-1:0]      r_rstart;
    logic                    r_last;
    logic [VW-1:0]           r_voice;
    logic [VH_W-1:0]         r_vhop;
    logic                    r_vact;
    t_sample                 r_rd_data;
    logic                    r_rd_ok;
    logic [WIN_W-1:0]        r_win;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_mvalid;
    logic [M_TDATA_W-1:0]    r_mdata;
    logic                    r_mlast;

    logic [GRAIN_W-1:0]      w_g;
    logic [HOP_W-1:0]        w_hop;
    logic                    w_in_xfer;
    logic                    w_start;
    logic [AW-1:0]           w_rd_addr;
    logic [PHASE_W-1:0]      w_phase;
    logic [IDXP_W-1:0]       w_idx_prod;
    logic [CW-1:0]           w_idx;
    t_sample                 w_smp;
    logic signed [WIN_W:0]   w_win_s;
    logic signed [PROD_W-1:0] w_prod;
    logic [GRAIN_W-1:0]      w_pos_nx;
    logic                    w_last_voice;
    logic                    w_rs_big;
    logic                    w_out_free;
    logic signed [ACC_W-1:0] w_biased;
    logic signed [ACC_W-1:0] w_shift;
    logic [M_TDATA_W-1:0]    w_sat;

    always_comb begin
        if (r_grain_size < GRAIN_MIN) begin
            w_g = GRAIN_MIN;
        end else if (r_grain_size > GRAIN_MAX) begin
            w_g = GRAIN_MAX;
        end else begin
            w_g = r_grain_size;
        end
    end

    assign w_hop        = w_g[GRAIN_W-1:2];
    assign w_in_xfer    = s_axis_tvalid && s_axis_tready;
    assign w_start      = !r_active[r_voice] && (r_vhop == VH_W'(r_sc));
    assign w_rd_addr    = w_start ? AW'(r_rstart) : r_raddr[r_voice];
    assign w_phase      = w_start ? '0 : r_phase[r_voice];
    assign w_idx_prod   = IDXP_W'(w_phase) * IDXP_W'(COS_TABLE_DEPTH);
    assign w_idx        = w_idx_prod[PHASE_W +: CW];
    assign w_smp        = r_rd_ok ? r_rd_data : '0;
    assign w_win_s      = {1'b0, r_win};
    assign w_prod       = w_smp * w_win_s;
    assign w_pos_nx     = r_pos[r_voice] + 1'b1;
    assign w_last_voice = (r_voice == VW'(VOICES - 1));
    assign w_rs_big     = (32'(r_rstart) >= BUF_DEPTH);
    assign w_out_free   = !r_mvalid || m_axis_tready;

    // round half up, then clamp
    assign w_biased = r_acc + ACC_W'(16384);
    assign w_shift  = w_biased >>> 15;
    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = M_TDATA_W'(SAT_HI);
        end else if (w_shift < SAT_LO) begin
            w_sat = M_TDATA_W'(SAT_LO);
        end else begin
            w_sat = w_shift[M_TDATA_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_LOAD;
            S_LOAD:  if (!w_rs_big) n_state = S_VSEL;
            S_VSEL:  n_state = S_VMUL;
            S_VMUL:  n_state = S_VACC;
            S_VACC:  n_state = w_last_voice ? S_WRAP : S_VSEL;
            S_WRAP:  if (r_sc < w_g) n_state = S_ROUND;
            S_ROUND: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sample store and window ROM reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_mem[r_waddr] <= r_smp;
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_ok   <= r_wrapped || (w_rd_addr <= r_waddr);
        r_win     <= w_win_rom[w_idx];
    end

    // voice payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_VSEL && w_start) begin
            r_raddr[r_voice] <= AW'(r_rstart);
            r_pos[r_voice]   <= '0;
            r_phase[r_voice] <= '0;
        end
        if (r_state == S_VACC && r_vact) begin
            r_raddr[r_voice] <= (r_raddr[r_voice] == AW'(BUF_DEPTH - 1)) ? '0
                                : r_raddr[r_voice] + 1'b1;
            r_phase[r_voice] <= r_phase[r_voice] + r_window_step[PHASE_W-1:0];
            r_pos[r_voice]   <= w_pos_nx;
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_smp    <= s_axis_tdata[SAMPLE_W-1:0];
                    r_rstart <= s_axis_tdata[SAMPLE_W +: START_W];
                    r_last   <= s_axis_tlast;
                    r_voice  <= '0;
                    r_vhop   <= '0;
                    r_acc    <= '0;
                end
            end
            S_LOAD: begin
                if (w_rs_big) begin
                    r_rstart <= r_rstart - START_W'(BUF_DEPTH);
                end
            end
            S_VSEL: begin
                r_vact <= r_active[r_voice] || w_start;
            end
            S_VMUL: begin
                r_prod <= w_prod;
            end
            S_VACC: begin
                if (r_vact) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                r_vhop  <= r_vhop + VH_W'(w_hop);
                r_voice <= r_voice + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grain_size  <= GRAIN_RESET;
            r_window_step <= STEP_RESET;
            r_waddr       <= '0;
            r_wrapped     <= 1'b0;
            r_sc          <= '0;
            r_mvalid      <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_active[v] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRAIN_SIZE:  r_grain_size  <= i_cfg_data[GRAIN_W-1:0];
                    CFG_WINDOW_STEP: r_window_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_VSEL && w_start) begin
                r_active[r_voice] <= 1'b1;
            end
            if (r_state == S_VACC) begin
                if (r_vact && w_pos_nx >= w_g) begin
                    r_active[r_voice] <= 1'b0;
                end
                if (w_last_voice) begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            // start counter modulo, one subtract per cycle
            if (r_state == S_WRAP && r_sc >= w_g) begin
                r_sc <= r_sc - w_g;
            end
            if (r_state == S_ROUND && w_out_free) begin
                r_mvalid <= 1'b1;
                if (r_waddr == AW'(BUF_DEPTH - 1)) begin
                    r_waddr   <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_waddr <= r_waddr + 1'b1;
                end
            end else if (r_mvalid && m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND && w_out_free) begin
            r_mdata <= w_sat;
            r_mlast <= r_last;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

endmodule

// ===== rtl/gsv_checker.sv =====
`include "granular_shuffle_voices_core_defines.svh"

module gsv_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [gsv_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // sample_out[15:0]
    input  logic                           m_axis_tlast   // block_last_out
);

    // reset leaves no result pending and the input side open
    `GSV_ASSERT_CLK(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "reset did not idle the block")

    // a sample is worked on before the next is taken: no transfer straight after another
    `GSV_ASSERT_RST(a_busy_after_xfer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

    // held result stays put
    `GSV_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind granular_shuffle_voices_core gsv_checker u_gsv_checker (.*);
